>>> sv/msr_pkg.sv
// Shared types and constants for the max-sum sub-rectangle block.
`default_nettype none

package msr_pkg;

    // Configuration register layout
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMN_COUNT = 1'd1;

    // Stream payload layout
    localparam int IN_TDATA_BITS  = 32;
    localparam int SUM_BITS       = 44;
    localparam int COORD_BITS     = 7;
    localparam int OUT_TDATA_BITS = SUM_BITS + 4 * COORD_BITS;

    localparam int TOP_ROW_LSB      = SUM_BITS;
    localparam int LEFT_COLUMN_LSB  = SUM_BITS + COORD_BITS;
    localparam int BOTTOM_ROW_LSB   = SUM_BITS + 2 * COORD_BITS;
    localparam int RIGHT_COLUMN_LSB = SUM_BITS + 3 * COORD_BITS;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_LD_WR    = 6'b000010,
        ST_SC_PRIME = 6'b000100,
        ST_SC_FIRST = 6'b001000,
        ST_SC_STEP  = 6'b010000,
        ST_DONE     = 6'b100000
    } msr_state_t;

endpackage

`default_nettype wire

>>> sv/msr_prefix_ram.sv
// Column prefix-sum memory: one write port, two registered read ports.
`default_nettype none

module msr_prefix_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 38
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [DATA_BITS-1:0] wdata,
    input  wire logic [ADDR_BITS-1:0] ra_addr,
    output logic      [DATA_BITS-1:0] ra_data,
    input  wire logic [ADDR_BITS-1:0] rb_addr,
    output logic      [DATA_BITS-1:0] rb_data
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] ra_data_reg;
    logic [DATA_BITS-1:0] rb_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two read ports, data registered
    always_ff @(posedge clk)
    begin
        ra_data_reg <= mem[ra_addr];
        rb_data_reg <= mem[rb_addr];
    end

    assign ra_data = ra_data_reg;
    assign rb_data = rb_data_reg;

endmodule

`default_nettype wire

>>> sv/max_sum_subrectangle.sv
// Top level: matrix loader, prefix store and 2-D Kadane scan sequencer.
//
// Channel   Dir  Handshake          Payload
// s_*       in   tvalid/tready      tdata[31:0] element_value
// m_*       out  tvalid/tready      tdata[71:0] best_sum, top_row, left_column,
//                                   bottom_row, right_column
// cfg_*     in   we (no wait)       index 0 row_count, 1 column_count
//
// Each element is handled as a read of the prefix above it, then the write.
// After the last element the scan runs n*(n+1)/2 row pairs, each a prime state,
// a first state and then a Kadane step per column, n = min(rows, columns),
// m = max(rows, columns), paced by the single Kadane adder/compare and the
// prefix memory's two read ports. The result then moves to the output
// register as soon as it is free; input is taken again in the next cycle.
// Reset clears control state only; row zero of the prefix store is implicit.
`default_nettype none

module max_sum_subrectangle
    import msr_pkg::*;
#(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 32
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    // element_value [31:0]
    input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // best_sum [43:0], top_row [50:44], left_column [57:51],
    // bottom_row [64:58], right_column [71:65]
    output logic [OUT_TDATA_BITS-1:0]      m_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_BITS-1:0]       cfg_data
);

    localparam int IDX_BITS  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int PSUM_BITS = ELEMENT_BITS + $clog2(MAX_DIM);
    localparam int RUN_BITS  = ELEMENT_BITS + 2 * $clog2(MAX_DIM);

    typedef logic [DIM_BITS-1:0] dim_t;

    function automatic dim_t clamp_dim(input logic [CFG_BITS-1:0] v);
        if (v == '0)
        begin
            return DIM_BITS'(1);
        end
        else if (32'(v) > 32'(MAX_DIM))
        begin
            return DIM_BITS'(MAX_DIM);
        end
        return DIM_BITS'(v);
    endfunction

    // Row r (1..MAX_DIM), column c (1..MAX_DIM) to memory address
    function automatic logic [ADDR_BITS-1:0] addr_of(input dim_t row, input dim_t col);
        dim_t r0;
        dim_t c0;
        r0 = row - DIM_BITS'(1);
        c0 = col - DIM_BITS'(1);
        return {r0[IDX_BITS-1:0], c0[IDX_BITS-1:0]};
    endfunction

    // Control registers
    msr_state_t state_reg, state_next;
    logic [CFG_BITS-1:0] row_count_reg, row_count_next;
    logic [CFG_BITS-1:0] column_count_reg, column_count_next;
    dim_t r_reg, r_next;
    dim_t c_reg, c_next;
    dim_t i_reg, i_next;
    dim_t k_reg, k_next;
    dim_t l_reg, l_next;
    logic out_valid_reg, out_valid_next;
    logic a_zero_reg, a_zero_next;
    logic b_zero_reg, b_zero_next;

    // Datapath registers
    logic signed [PSUM_BITS-1:0] x_reg, x_next;
    logic signed [PSUM_BITS-1:0] cs_reg, cs_next;
    logic signed [RUN_BITS-1:0]  run_reg, run_next;
    dim_t                        j_reg, j_next;
    logic signed [RUN_BITS-1:0]  best_reg, best_next;
    dim_t bi_reg, bi_next;
    dim_t bj_reg, bj_next;
    dim_t bk_reg, bk_next;
    dim_t bl_reg, bl_next;
    logic [OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    // Memory interface
    logic                  mem_we;
    logic [ADDR_BITS-1:0]  mem_waddr;
    logic [PSUM_BITS-1:0]  mem_wdata;
    logic [ADDR_BITS-1:0]  ra_addr;
    logic [ADDR_BITS-1:0]  rb_addr;
    logic [PSUM_BITS-1:0]  ra_data;
    logic [PSUM_BITS-1:0]  rb_data;

    // Geometry
    dim_t rows;
    dim_t cols;
    dim_t n_dim;
    dim_t m_dim;
    dim_t si;
    dim_t sj;
    dim_t rd_col;
    logic transpose;

    // Shared Kadane unit
    logic signed [PSUM_BITS-1:0] a_val;
    logic signed [PSUM_BITS-1:0] b_val;
    logic signed [PSUM_BITS-1:0] diff;
    logic signed [RUN_BITS-1:0]  run_base;
    logic signed [RUN_BITS-1:0]  run_sum;
    dim_t                        j_new;
    logic                        check;
    logic                        better;

    logic signed [63:0] best_wide;
    dim_t o_top, o_left, o_bottom, o_right;

    msr_prefix_ram #(
        .ADDR_BITS(ADDR_BITS),
        .DATA_BITS(PSUM_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    // Dimensions and stored orientation
    assign rows      = clamp_dim(row_count_reg);
    assign cols      = clamp_dim(column_count_reg);
    assign transpose = rows > cols;
    assign n_dim     = transpose ? cols : rows;
    assign m_dim     = transpose ? rows : cols;
    assign si        = transpose ? c_reg : r_reg;
    assign sj        = transpose ? r_reg : c_reg;

    // Column difference of the two prefix rows just read
    assign a_val = a_zero_reg ? '0 : signed'(ra_data);
    assign b_val = b_zero_reg ? '0 : signed'(rb_data);
    assign diff  = a_val - b_val;

    // One Kadane step for column l
    assign run_base = run_reg[RUN_BITS-1] ? '0 : run_reg;
    assign j_new    = run_reg[RUN_BITS-1] ? l_reg : j_reg;
    assign run_sum  = run_base + RUN_BITS'(cs_reg);
    assign check    = (l_reg == m_dim) || diff[PSUM_BITS-1];
    assign better   = check && (run_sum > best_reg);

    // Read addressing: load reads the prefix above; scan reads rows k and i-1
    always_comb
    begin
        unique case (state_reg)
            ST_SC_PRIME: rd_col = DIM_BITS'(1);
            ST_SC_FIRST: rd_col = DIM_BITS'(2);
            default:     rd_col = l_reg + DIM_BITS'(2);
        endcase
    end

    assign ra_addr     = (state_reg == ST_IDLE) ? addr_of(si - DIM_BITS'(1), sj)
                                                : addr_of(k_reg, rd_col);
    assign rb_addr     = addr_of(i_reg - DIM_BITS'(1), rd_col);
    assign a_zero_next = (state_reg == ST_IDLE) && (si == DIM_BITS'(1));
    assign b_zero_next = (i_reg == DIM_BITS'(1));

    assign mem_waddr = addr_of(si, sj);
    assign mem_wdata = x_reg + a_val;

    // Result packing, corners swapped back when stored transposed
    assign best_wide = 64'(best_reg);
    assign o_top     = transpose ? bj_reg : bi_reg;
    assign o_left    = transpose ? bi_reg : bj_reg;
    assign o_bottom  = transpose ? bl_reg : bk_reg;
    assign o_right   = transpose ? bk_reg : bl_reg;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        r_next            = r_reg;
        c_next            = c_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        l_next            = l_reg;
        out_valid_next    = out_valid_reg;
        x_next            = x_reg;
        cs_next           = cs_reg;
        run_next          = run_reg;
        j_next            = j_reg;
        best_next         = best_reg;
        bi_next           = bi_reg;
        bj_next           = bj_reg;
        bk_next           = bk_reg;
        bl_next           = bl_reg;
        out_data_next     = out_data_reg;
        mem_we            = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = PSUM_BITS'(signed'(s_tdata[ELEMENT_BITS-1:0]));
                    state_next = ST_LD_WR;
                end
            end
            ST_LD_WR:
            begin
                mem_we = 1'b1;
                if (c_reg == cols)
                begin
                    c_next = DIM_BITS'(1);
                    if (r_reg == rows)
                    begin
                        r_next     = DIM_BITS'(1);
                        i_next     = DIM_BITS'(1);
                        k_next     = DIM_BITS'(1);
                        state_next = ST_SC_PRIME;
                    end
                    else
                    begin
                        r_next     = r_reg + DIM_BITS'(1);
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    c_next     = c_reg + DIM_BITS'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_SC_PRIME:
            begin
                state_next = ST_SC_FIRST;
            end
            ST_SC_FIRST:
            begin
                cs_next  = diff;
                run_next = '1;
                j_next   = DIM_BITS'(1);
                l_next   = DIM_BITS'(1);
                // Best starts as element (1,1)
                if ((i_reg == DIM_BITS'(1)) && (k_reg == DIM_BITS'(1)))
                begin
                    best_next = RUN_BITS'(diff);
                    bi_next   = DIM_BITS'(1);
                    bj_next   = DIM_BITS'(1);
                    bk_next   = DIM_BITS'(1);
                    bl_next   = DIM_BITS'(1);
                end
                state_next = ST_SC_STEP;
            end
            ST_SC_STEP:
            begin
                run_next = run_sum;
                j_next   = j_new;
                cs_next  = diff;
                l_next   = l_reg + DIM_BITS'(1);
                if (better)
                begin
                    best_next = run_sum;
                    bi_next   = i_reg;
                    bj_next   = j_new;
                    bk_next   = k_reg;
                    bl_next   = l_reg;
                end
                // Row pair finished
                if (l_reg == m_dim)
                begin
                    if (k_reg != n_dim)
                    begin
                        k_next     = k_reg + DIM_BITS'(1);
                        state_next = ST_SC_PRIME;
                    end
                    else if (i_reg != n_dim)
                    begin
                        i_next     = i_reg + DIM_BITS'(1);
                        k_next     = i_reg + DIM_BITS'(1);
                        state_next = ST_SC_PRIME;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {COORD_BITS'(o_right), COORD_BITS'(o_bottom),
                                      COORD_BITS'(o_left), COORD_BITS'(o_top),
                                      best_wide[SUM_BITS-1:0]};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes restart the matrix
        if (cfg_we)
        begin
            r_next = DIM_BITS'(1);
            c_next = DIM_BITS'(1);
            unique case (cfg_index)
                CFG_ROW_COUNT:    row_count_next    = cfg_data;
                CFG_COLUMN_COUNT: column_count_next = cfg_data;
                default:          ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            row_count_reg    <= CFG_BITS'(1);
            column_count_reg <= CFG_BITS'(1);
            r_reg            <= DIM_BITS'(1);
            c_reg            <= DIM_BITS'(1);
            i_reg            <= DIM_BITS'(1);
            k_reg            <= DIM_BITS'(1);
            l_reg            <= DIM_BITS'(1);
            out_valid_reg    <= 1'b0;
            a_zero_reg       <= 1'b0;
            b_zero_reg       <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
            r_reg            <= r_next;
            c_reg            <= c_next;
            i_reg            <= i_next;
            k_reg            <= k_next;
            l_reg            <= l_next;
            out_valid_reg    <= out_valid_next;
            a_zero_reg       <= a_zero_next;
            b_zero_reg       <= b_zero_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        cs_reg       <= cs_next;
        run_reg      <= run_next;
        j_reg        <= j_next;
        best_reg     <= best_next;
        bi_reg       <= bi_next;
        bj_reg       <= bj_next;
        bk_reg       <= bk_next;
        bl_reg       <= bl_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> sv/msr_checker.sv
// Port-level checks for the max-sum sub-rectangle block, bound to the top level.
`default_nettype none

module msr_checker
    import msr_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic [OUT_TDATA_BITS-1:0] m_tdata,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready
);

    // A stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every element transfer is followed by the memory write cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the element was stored");

    // A new result appears only at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a finished scan");

    // Corners are ordered and counted from one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tdata[TOP_ROW_LSB +: COORD_BITS] != '0) &&
            (m_tdata[LEFT_COLUMN_LSB +: COORD_BITS] != '0) &&
            (m_tdata[TOP_ROW_LSB +: COORD_BITS] <= m_tdata[BOTTOM_ROW_LSB +: COORD_BITS]) &&
            (m_tdata[LEFT_COLUMN_LSB +: COORD_BITS] <=
                m_tdata[RIGHT_COLUMN_LSB +: COORD_BITS]))
        else $error("result corners out of order");

endmodule

bind max_sum_subrectangle msr_checker u_msr_checker (.*);

`default_nettype wire
